@@ hw/rtl/lcdlw_pkg.sv @@
// Shared types, codes and the expander frame builder for the LCD line writer.
// No dependencies; the datapath, the controller and the top level import this package.
package lcdlw_pkg;

  localparam int MAX_COLUMNS_DEF = 40;
  localparam int COL_W = 6;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_CHAR  = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  localparam logic [1:0] REG_ROWS_MODE   = 2'd0;
  localparam logic [1:0] REG_LINE_LENGTH = 2'd1;
  localparam logic [1:0] REG_ENABLE      = 2'd2;
  localparam logic [1:0] REG_BACKLIGHT   = 2'd3;

  localparam logic [1:0] ROWS_ONE = 2'd0;
  localparam logic [1:0] ROWS_TWO = 2'd1;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_SPACE = 2'd2;

  localparam logic [7:0] ADDR_ROW_ODD  = 8'h80;
  localparam logic [7:0] ADDR_ROW_EVEN = 8'hC0;
  localparam logic [7:0] SPACE_CODE    = 8'h20;
  localparam logic       MODE_DATA     = 1'b1;
  localparam logic       MODE_CMD      = 1'b0;

  typedef struct packed {
    logic       emit;
    logic [1:0] kind;
    logic       clr_col;
    logic       inc_col;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic next_full;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b5;
  } frame_t;

  // Each nibble goes out as three bytes: strobe low, strobe high, strobe cleared.
  function automatic frame_t make_frame(logic [7:0] value, logic mode,
                                        logic [7:0] en, logic [7:0] bl);
    logic [7:0] hi;
    logic [7:0] lo;
    frame_t     f;
    hi   = {value[7:4], 3'b000, mode};
    lo   = {value[3:0], 3'b000, mode};
    f.b0 = hi | bl;
    f.b1 = hi | en | bl;
    f.b2 = (hi & ~en) | bl;
    f.b3 = lo | bl;
    f.b4 = lo | en | bl;
    f.b5 = (lo & ~en) | bl;
    return f;
  endfunction

endpackage

@@ hw/rtl/lcdlw_ifs.sv @@
// Valid/ready channel interfaces for line items and expander frames.
// Depends on nothing; used by the top level and the datapath.
interface lcdlw_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [2:0] row;
  logic [7:0] char_code;
  logic       pad_line;

  modport source (output valid, action, row, char_code, pad_line, input ready);
  modport sink   (input valid, action, row, char_code, pad_line, output ready);
endinterface

interface lcdlw_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte_0;
  logic [7:0] frame_byte_1;
  logic [7:0] frame_byte_2;
  logic [7:0] frame_byte_3;
  logic [7:0] frame_byte_4;
  logic [7:0] frame_byte_5;
  logic       last_of_run;
  logic       bad_row;

  modport source (output valid, frame_byte_0, frame_byte_1, frame_byte_2, frame_byte_3,
                  frame_byte_4, frame_byte_5, last_of_run, bad_row, input ready);
  modport sink   (input valid, frame_byte_0, frame_byte_1, frame_byte_2, frame_byte_3,
                  frame_byte_4, frame_byte_5, last_of_run, bad_row, output ready);
endinterface

@@ hw/rtl/lcdlw_datapath.sv @@
// Datapath: configuration registers, column counter and the output frame register.
// Depends on lcdlw_pkg and lcdlw_frame_if; driven by lcdlw_ctrl through cmd_t.
module lcdlw_datapath import lcdlw_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic [2:0]         row,
  input  logic [7:0]         char_code,
  input  cmd_t               cmd,
  output status_t            status,
  lcdlw_frame_if.source      frames
);

  logic [1:0]       rows_mode;
  logic [COL_W-1:0] line_length;
  logic [7:0]       enable_mask;
  logic [7:0]       backlight_mask;
  logic [COL_W-1:0] column_count;
  logic             out_valid;
  frame_t           frame;
  logic             last_of_run;
  logic             bad_row;

  logic [COL_W-1:0] eff_len;
  logic [COL_W:0]   col_plus;
  logic [2:0]       rows_allowed;
  logic             row_bad;
  logic [7:0]       row_addr;
  logic [7:0]       wr_byte;
  logic             wr_mode;

  assign eff_len  = (line_length > COL_W'(MAX_COLUMNS)) ? COL_W'(MAX_COLUMNS) : line_length;
  assign col_plus = {1'b0, column_count} + (COL_W+1)'(1);

  assign status.full      = column_count >= eff_len;
  assign status.next_full = col_plus == {1'b0, eff_len};
  assign status.out_free  = !out_valid || frames.ready;

  always_comb begin
    case (rows_mode)
      ROWS_ONE: rows_allowed = 3'd1;
      ROWS_TWO: rows_allowed = 3'd2;
      default:  rows_allowed = 3'd4;
    endcase
  end

  assign row_bad  = (row == 3'd0) || (row > rows_allowed);
  // Rows three and four continue rows one and two past the end of the visible line.
  assign row_addr = (row[0] ? ADDR_ROW_ODD : ADDR_ROW_EVEN)
                    + ((row > 3'd2) ? {2'b00, eff_len} : 8'd0);

  always_comb begin
    case (cmd.kind)
      KIND_START: begin
        wr_byte = row_addr;
        wr_mode = MODE_CMD;
      end
      KIND_CHAR: begin
        wr_byte = char_code;
        wr_mode = MODE_DATA;
      end
      default: begin
        wr_byte = SPACE_CODE;
        wr_mode = MODE_DATA;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_mode      <= 2'd1;
      line_length    <= COL_W'(16);
      enable_mask    <= 8'd4;
      backlight_mask <= 8'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_MODE:   rows_mode      <= cfg_data[1:0];
        REG_LINE_LENGTH: line_length    <= cfg_data[COL_W-1:0];
        REG_ENABLE:      enable_mask    <= cfg_data;
        REG_BACKLIGHT:   backlight_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
    end else if (cmd.clr_col) begin
      column_count <= '0;
    end else if (cmd.inc_col) begin
      column_count <= col_plus[COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (frames.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last_of_run <= cmd.last;
      if (cmd.kind == KIND_START && row_bad) begin
        frame   <= '0;
        bad_row <= 1'b1;
      end else begin
        frame   <= make_frame(wr_byte, wr_mode, enable_mask, backlight_mask);
        bad_row <= 1'b0;
      end
    end
  end

  assign frames.valid        = out_valid;
  assign frames.frame_byte_0 = frame.b0;
  assign frames.frame_byte_1 = frame.b1;
  assign frames.frame_byte_2 = frame.b2;
  assign frames.frame_byte_3 = frame.b3;
  assign frames.frame_byte_4 = frame.b4;
  assign frames.frame_byte_5 = frame.b5;
  assign frames.last_of_run  = last_of_run;
  assign frames.bad_row      = bad_row;

endmodule

@@ hw/rtl/lcdlw_ctrl.sv @@
// Controller: decodes accepted items and sequences the space writes of line padding.
// Depends on lcdlw_pkg; commands lcdlw_datapath through cmd_t and reads status_t.
module lcdlw_ctrl import lcdlw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] action,
  input  logic       pad_line,
  input  status_t    status,
  output logic       in_ready,
  output cmd_t       cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_PAD  = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = status.out_free;
        if (in_valid && status.out_free) begin
          case (action)
            ACT_START: begin
              cmd.emit    = 1'b1;
              cmd.kind    = KIND_START;
              cmd.clr_col = 1'b1;
              cmd.last    = 1'b1;
            end
            ACT_CHAR: begin
              if (!status.full) begin
                cmd.emit    = 1'b1;
                cmd.kind    = KIND_CHAR;
                cmd.inc_col = 1'b1;
                cmd.last    = 1'b1;
              end
            end
            ACT_END: begin
              if (pad_line && !status.full) begin
                cmd.emit    = 1'b1;
                cmd.kind    = KIND_SPACE;
                cmd.inc_col = 1'b1;
                cmd.last    = status.next_full;
                if (!status.next_full) begin
                  state_next = S_PAD;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_PAD: begin
        // One space per free output slot until the column counter reaches the line end.
        if (status.out_free) begin
          cmd.emit    = 1'b1;
          cmd.kind    = KIND_SPACE;
          cmd.inc_col = 1'b1;
          cmd.last    = status.next_full;
          if (status.next_full) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hw/rtl/char_lcd_line_writer.sv @@
// Character LCD line writer: turns line items into 4-bit expander write frames.
// Input channel "chars" carries items (start line, character, end line); output
// channel "frames" carries one six-byte expander write per transaction, plus
// last_of_run and bad_row flags.
// A start or character item is taken when the output is free, and its frame is valid
// in the cycle after. An end-line item with padding gives one space frame per cycle
// while frames.ready is high, one per free column, and chars.ready stays low until
// the last space frame is loaded. Start and character items are taken at one item per
// cycle while frames.ready is high; padding spaces pass the single output register.
// A character past the line end or an unused action is absorbed with no frame.
// When the receiver holds frames.ready low, the output register holds its frame
// and chars.ready drops, so no new item is taken until the frame leaves.
// Synchronous reset restores the register defaults (two rows, 16 columns,
// enable 0x04, backlight 0x08), clears the column counter and empties the output.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the user must write them
// only while idle; the block does not enforce it. Depends on lcdlw_pkg, lcdlw_ifs, lcdlw_ctrl and lcdlw_datapath.
module char_lcd_line_writer import lcdlw_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  lcdlw_item_if.sink    chars,
  lcdlw_frame_if.source frames
);

  cmd_t    cmd;
  status_t status;

  lcdlw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chars.valid),
    .action   (chars.action),
    .pad_line (chars.pad_line),
    .status   (status),
    .in_ready (chars.ready),
    .cmd      (cmd)
  );

  lcdlw_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .row       (chars.row),
    .char_code (chars.char_code),
    .cmd       (cmd),
    .status    (status),
    .frames    (frames)
  );

endmodule

@@ hw/rtl/lcdlw_checker.sv @@
// Port-level checks for the LCD line writer, bound to the top level.
// Depends only on the top level's ports.
module lcdlw_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] frame_byte_0,
  input logic [7:0] frame_byte_1,
  input logic [7:0] frame_byte_2,
  input logic [7:0] frame_byte_3,
  input logic [7:0] frame_byte_4,
  input logic [7:0] frame_byte_5,
  input logic       last_of_run,
  input logic       bad_row
);

  // A bad-row result is always a single, all-zero frame.
  a_bad_row_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_row |-> last_of_run && frame_byte_0 == 8'd0 && frame_byte_1 == 8'd0
      && frame_byte_2 == 8'd0 && frame_byte_3 == 8'd0 && frame_byte_4 == 8'd0
      && frame_byte_5 == 8'd0)
    else $error("bad-row frame carries data or is not last");

  // While a padding run is unfinished, no new item may be taken.
  a_no_accept_mid_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> !in_ready)
    else $error("input accepted in the middle of a padding run");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_byte_0) && $stable(frame_byte_5)
      && $stable(last_of_run) && $stable(bad_row))
    else $error("stalled frame changed");

endmodule

bind char_lcd_line_writer lcdlw_checker u_lcdlw_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (chars.ready),
  .out_valid    (frames.valid),
  .out_ready    (frames.ready),
  .frame_byte_0 (frames.frame_byte_0),
  .frame_byte_1 (frames.frame_byte_1),
  .frame_byte_2 (frames.frame_byte_2),
  .frame_byte_3 (frames.frame_byte_3),
  .frame_byte_4 (frames.frame_byte_4),
  .frame_byte_5 (frames.frame_byte_5),
  .last_of_run  (frames.last_of_run),
  .bad_row      (frames.bad_row)
);

@@ sim/tb_char_lcd_line_writer.sv @@
// Self-checking testbench for char_lcd_line_writer: directed and random line items
// against a built-in frame predictor. Needs lcdlw_pkg, lcdlw_ifs and the RTL top.
module tb_char_lcd_line_writer;
  import lcdlw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    frame_t bytes;
    logic   last;
    logic   bad;
  } lcd_result_t;

  class lcd_frame_scoreboard;
    lcd_result_t frames_due[$];
    logic [1:0]  rows_mode;
    logic [5:0]  line_len;
    logic [7:0]  strobe;
    logic [7:0]  backlight;
    logic [5:0]  column;
    int          mismatches;

    function new();
      rows_mode  = ROWS_TWO;
      line_len   = 6'd16;
      strobe     = 8'h04;
      backlight  = 8'h08;
      column     = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] value);
      case (idx)
        REG_ROWS_MODE:   rows_mode = value[1:0];
        REG_LINE_LENGTH: line_len = value[5:0];
        REG_ENABLE:      strobe = value;
        REG_BACKLIGHT:   backlight = value;
        default:         ;
      endcase
    endfunction

    // Lengths above the column limit behave as the limit itself.
    function logic [5:0] usable_len();
      return (line_len > MAX_COLUMNS_DEF) ? 6'(MAX_COLUMNS_DEF) : line_len;
    endfunction

    function int rows_allowed();
      if (rows_mode == ROWS_ONE) return 1;
      if (rows_mode == ROWS_TWO) return 2;
      return 4;
    endfunction

    function void push_write(logic [7:0] value, logic mode, logic last);
      lcd_result_t r;
      logic [7:0]  hi;
      logic [7:0]  lo;
      hi = (value & 8'hF0) | {7'd0, mode};
      lo = {value[3:0], 4'h0} | {7'd0, mode};
      r.bytes.b0 = hi | backlight;
      r.bytes.b1 = hi | strobe | backlight;
      r.bytes.b2 = (hi & ~strobe) | backlight;
      r.bytes.b3 = lo | backlight;
      r.bytes.b4 = lo | strobe | backlight;
      r.bytes.b5 = (lo & ~strobe) | backlight;
      r.last     = last;
      r.bad      = 1'b0;
      frames_due.push_back(r);
    endfunction

    function void note_item(logic [1:0] action, logic [2:0] row, logic [7:0] code,
                            logic pad);
      lcd_result_t r;
      logic [5:0]  len;
      logic [7:0]  addr;
      len = usable_len();
      case (action)
        ACT_START: begin
          column = '0;
          if (row == 0 || row > rows_allowed()) begin
            r      = '0;
            r.last = 1'b1;
            r.bad  = 1'b1;
            frames_due.push_back(r);
          end else begin
            addr = row[0] ? ADDR_ROW_ODD : ADDR_ROW_EVEN;
            if (row > 2) addr = addr + {2'b00, len};
            push_write(addr, MODE_CMD, 1'b1);
          end
        end
        ACT_CHAR: begin
          if (column < len) begin
            push_write(code, MODE_DATA, 1'b1);
            column = column + 6'd1;
          end
        end
        ACT_END: begin
          if (pad) begin
            while (column < len) begin
              push_write(SPACE_CODE, MODE_DATA, column == len - 6'd1);
              column = column + 6'd1;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_frame(lcd_result_t got);
      lcd_result_t want;
      if (frames_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected frame %h %h %h %h %h %h last=%b bad=%b",
                   got.bytes.b0, got.bytes.b1, got.bytes.b2, got.bytes.b3,
                   got.bytes.b4, got.bytes.b5, got.last, got.bad);
        return;
      end
      want = frames_due.pop_front();
      if (got.bytes.b0 !== want.bytes.b0 || got.bytes.b1 !== want.bytes.b1 ||
          got.bytes.b2 !== want.bytes.b2 || got.bytes.b3 !== want.bytes.b3 ||
          got.bytes.b4 !== want.bytes.b4 || got.bytes.b5 !== want.bytes.b5 ||
          got.last !== want.last || got.bad !== want.bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("frame mismatch: expected %h %h %h %h %h %h last=%b bad=%b",
                   want.bytes.b0, want.bytes.b1, want.bytes.b2, want.bytes.b3,
                   want.bytes.b4, want.bytes.b5, want.last, want.bad);
          $display("                actual   %h %h %h %h %h %h last=%b bad=%b",
                   got.bytes.b0, got.bytes.b1, got.bytes.b2, got.bytes.b3,
                   got.bytes.b4, got.bytes.b5, got.last, got.bad);
        end
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  bit         calm;
  int         items_sent;

  lcd_frame_scoreboard board;

  lcdlw_item_if  chars_if ();
  lcdlw_frame_if frames_if ();

  char_lcd_line_writer uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .chars     (chars_if),
    .frames    (frames_if)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  // Frame receiver: checks each transaction and stalls at random outside calm phases.
  initial begin
    lcd_result_t got;
    frames_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && frames_if.valid && frames_if.ready) begin
        got.bytes.b0 = frames_if.frame_byte_0;
        got.bytes.b1 = frames_if.frame_byte_1;
        got.bytes.b2 = frames_if.frame_byte_2;
        got.bytes.b3 = frames_if.frame_byte_3;
        got.bytes.b4 = frames_if.frame_byte_4;
        got.bytes.b5 = frames_if.frame_byte_5;
        got.last     = frames_if.last_of_run;
        got.bad      = frames_if.bad_row;
        board.check_frame(got);
      end
      frames_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 33);
    end
  end

  // Returns at the edge where the item was taken, with valid still high.
  task automatic send_item(logic [1:0] action, logic [2:0] row, logic [7:0] code,
                           logic pad);
    int gap;
    gap = (!calm && $urandom_range(99) < 33) ? $urandom_range(1, 2) : 0;
    if (gap > 0) begin
      chars_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars_if.valid     <= 1'b1;
    chars_if.action    <= action;
    chars_if.row       <= row;
    chars_if.char_code <= code;
    chars_if.pad_line  <= pad;
    do @(posedge clk); while (!chars_if.ready);
    board.note_item(action, row, code, pad);
    items_sent++;
  endtask

  // An absorbed item may still be in flight when the queue empties, hence the tail.
  task automatic drain_frames();
    chars_if.valid <= 1'b0;
    while (board.frames_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic [1:0] rows, logic [5:0] len, logic [7:0] en,
                            logic [7:0] bl);
    logic [7:0] values [4];
    values = '{{6'd0, rows}, {2'b00, len}, en, bl};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= values[i];
      @(posedge clk);
      board.set_reg(2'(i), values[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_config();
    int         pick;
    logic [5:0] len;
    pick = $urandom_range(99);
    if (pick < 10) len = 6'd0;
    else if (pick < 20) len = 6'($urandom_range(41, 63));
    else if (pick < 30) len = 6'(MAX_COLUMNS_DEF);
    else len = 6'($urandom_range(1, 12));
    set_config(2'($urandom_range(0, 3)), len, 8'($urandom), 8'($urandom));
  endtask

  // Usually a start, then some characters (sometimes past the end of the line) and an end.
  task automatic random_line();
    int len;
    int n_chars;
    len = board.usable_len();
    if ($urandom_range(99) < 85)
      send_item(ACT_START, 3'($urandom_range(1, board.rows_allowed())), 8'h00, 1'b0);
    else if ($urandom_range(1) == 0)
      send_item(ACT_START, 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
    if (len > 10 && $urandom_range(99) < 70) n_chars = $urandom_range(0, 6);
    else n_chars = $urandom_range(0, len + 2);
    repeat (n_chars) send_item(ACT_CHAR, 3'($urandom), 8'($urandom), 1'($urandom));
    send_item(ACT_END, 3'($urandom), 8'($urandom), $urandom_range(99) < 75);
  endtask

  initial begin
    int phase;
    int phase_end;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_ROWS_MODE;
    cfg_data           <= 8'h00;
    chars_if.valid     <= 1'b0;
    chars_if.action    <= ACT_START;
    chars_if.row       <= 3'd0;
    chars_if.char_code <= 8'h00;
    chars_if.pad_line  <= 1'b0;
    calm               = 1'b0;
    items_sent         = 0;
    board              = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: two rows of 16. A character before any start is still written.
    send_item(ACT_CHAR, 3'd0, 8'h41, 1'b0);
    send_item(ACT_START, 3'd1, 8'h00, 1'b0);
    send_item(ACT_START, 3'd2, 8'h00, 1'b0);
    send_item(ACT_START, 3'd3, 8'h00, 1'b0);
    send_item(ACT_START, 3'd0, 8'h00, 1'b0);
    send_item(ACT_START, 3'd7, 8'hFF, 1'b1);
    send_item(ACT_CHAR, 3'd0, 8'h00, 1'b0);
    send_item(ACT_CHAR, 3'd7, 8'hFF, 1'b1);
    send_item(ACT_END, 3'd0, 8'h00, 1'b0);
    send_item(ACT_END, 3'd0, 8'h00, 1'b1);
    send_item(ACT_CHAR, 3'd0, 8'h7E, 1'b0);
    send_item(ACT_END, 3'd0, 8'h00, 1'b1);
    send_item(2'd3, 3'd5, 8'hAA, 1'b1);
    drain_frames();

    set_config(2'd2, 6'd40, 8'hFF, 8'h00);
    send_item(ACT_START, 3'd3, 8'h00, 1'b0);
    send_item(ACT_START, 3'd4, 8'h00, 1'b0);
    send_item(ACT_CHAR, 3'd0, 8'hA5, 1'b0);
    send_item(ACT_END, 3'd0, 8'h00, 1'b1);
    drain_frames();

    // Row mode three acts as four rows; an oversized length saturates.
    set_config(2'd3, 6'd63, 8'h00, 8'hFF);
    send_item(ACT_START, 3'd4, 8'h00, 1'b0);
    send_item(ACT_END, 3'd0, 8'h00, 1'b1);
    drain_frames();

    set_config(ROWS_ONE, 6'd1, 8'h55, 8'hAA);
    send_item(ACT_START, 3'd1, 8'h00, 1'b0);
    send_item(ACT_START, 3'd2, 8'h00, 1'b0);
    send_item(ACT_CHAR, 3'd0, 8'h3C, 1'b0);
    send_item(ACT_CHAR, 3'd0, 8'hC3, 1'b0);
    drain_frames();

    // A zero-length line takes no characters and no padding.
    set_config(2'd2, 6'd0, 8'h04, 8'h08);
    send_item(ACT_START, 3'd3, 8'h00, 1'b0);
    send_item(ACT_CHAR, 3'd0, 8'h31, 1'b0);
    send_item(ACT_END, 3'd0, 8'h00, 1'b1);
    drain_frames();

    phase = 0;
    while (items_sent < 200) begin
      random_config();
      calm      = (phase == 1);
      phase_end = items_sent + $urandom_range(30, 45);
      while (items_sent < phase_end) begin
        if ($urandom_range(99) < 15)
          send_item(2'($urandom), 3'($urandom), 8'($urandom), 1'($urandom));
        else
          random_line();
      end
      drain_frames();
      phase++;
    end
    calm = 1'b0;
    repeat (8) @(posedge clk);

    if (board.mismatches == 0 && board.frames_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/lcdlw_pkg.sv
hw/rtl/lcdlw_ifs.sv
hw/rtl/lcdlw_datapath.sv
hw/rtl/lcdlw_ctrl.sv
hw/rtl/char_lcd_line_writer.sv
hw/rtl/lcdlw_checker.sv
sim/tb_char_lcd_line_writer.sv
